// ===== sv/rfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfb_pkg: shared types for the rectangle fill blend engine
// Blend mode codes, configuration register indexes and the register file
// struct handed from the top level to the front and back sections.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int unsigned PIX_W      = 32;
	localparam int unsigned CH_W       = 8;
	localparam int unsigned NUM_CH     = PIX_W / CH_W;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned OFFSET_W   = 24;
	localparam int unsigned DIM_CFG_W  = 13;
	localparam int unsigned PITCH_W    = 14;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned QUEUE_DEPTH = 4;

	// blend mode codes; codes five to seven pass the pixel through
	typedef enum logic [MODE_W-1:0] {
		BLEND_ADD = 3'd0,
		BLEND_SUB = 3'd1,
		BLEND_MIN = 3'd2,
		BLEND_MAX = 3'd3,
		BLEND_MUL = 3'd4
	} blend_mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILL_COLOR   = 3'd0,
		REG_BLEND_MODE   = 3'd1,
		REG_ALPHA_MASK   = 3'd2,
		REG_RGBA_MODE    = 3'd3,
		REG_START_OFFSET = 3'd4,
		REG_RECT_WIDTH   = 3'd5,
		REG_RECT_HEIGHT  = 3'd6,
		REG_ROW_PITCH    = 3'd7
	} cfg_index_t;

	typedef logic [OFFSET_W-1:0] addr_out_t;

	// register file contents
	typedef struct packed {
		logic [PIX_W-1:0]     fill_color;
		blend_mode_t          blend_mode;
		logic [PIX_W-1:0]     alpha_mask;
		logic                 rgba_mode;
		logic [OFFSET_W-1:0]  start_offset;
		logic [DIM_CFG_W-1:0] rect_width;
		logic [DIM_CFG_W-1:0] rect_height;
		logic [PITCH_W-1:0]   row_pitch;
	} cfg_regs_t;

endpackage
`default_nettype wire

// ===== sv/rect_fill_blend_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rect_fill_blend_engine: rectangle fill with blend modes
// Blends a fill color into a raster stream of destination pixels and forms
// the write address and last flag of each pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration transactions (cfg_valid/cfg_ready, cfg_index, cfg_data) load
//   the eight registers; cfg_ready is always high. Write them only while the
//   engine holds no pixel in flight.
//   Pixel transactions (pixel_valid/pixel_ready, pixel_in) carry destination
//   pixels in raster order. Result transactions (result_valid/result_ready)
//   carry pixel_addr, pixel_out and last_pixel, one per pixel, in order.
//   An accepted pixel passes the four-entry queue, back stage one (blend and
//   one multiplier for row times pitch) and back stage two (the address
//   adder), which drives result_valid. Throughput is one pixel per cycle
//   until the receiver stalls; then the back pipeline holds and the queue
//   absorbs up to four more pixels before pixel_ready drops.
//   Reset clears the configuration registers, the row and column counters and the queue;
//   after the last pixel of a rectangle the scan wraps to its top-left corner.
// ----------------------------------------------------------------------------
module rect_fill_blend_engine #(
	parameter int unsigned ADDR_BITS = 24,
	parameter int unsigned MAX_DIM   = 4096
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [rfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [rfb_pkg::PIX_W-1:0]       cfg_data,
	input  wire                            pixel_valid,
	output logic                           pixel_ready,
	input  wire [rfb_pkg::PIX_W-1:0]       pixel_in,
	output logic                           result_valid,
	input  wire                            result_ready,
	output logic [rfb_pkg::OFFSET_W-1:0]   pixel_addr,
	output logic [rfb_pkg::PIX_W-1:0]      pixel_out,
	output logic                           last_pixel
);

	localparam int unsigned CNT_W  = $clog2(MAX_DIM);
	localparam int unsigned DATA_W = rfb_pkg::PIX_W + 2 * CNT_W + 1;

	rfb_pkg::cfg_regs_t cfg_q;
	logic              push_valid;
	logic              push_ready;
	logic [DATA_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [DATA_W-1:0] pop_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (rfb_pkg::cfg_index_t'(cfg_index))
				rfb_pkg::REG_FILL_COLOR:   cfg_q.fill_color <= cfg_data;
				rfb_pkg::REG_BLEND_MODE:
					cfg_q.blend_mode <= rfb_pkg::blend_mode_t'(cfg_data[rfb_pkg::MODE_W-1:0]);
				rfb_pkg::REG_ALPHA_MASK:   cfg_q.alpha_mask <= cfg_data;
				rfb_pkg::REG_RGBA_MODE:    cfg_q.rgba_mode <= cfg_data[0];
				rfb_pkg::REG_START_OFFSET:
					cfg_q.start_offset <= cfg_data[rfb_pkg::OFFSET_W-1:0];
				rfb_pkg::REG_RECT_WIDTH:
					cfg_q.rect_width <= cfg_data[rfb_pkg::DIM_CFG_W-1:0];
				rfb_pkg::REG_RECT_HEIGHT:
					cfg_q.rect_height <= cfg_data[rfb_pkg::DIM_CFG_W-1:0];
				rfb_pkg::REG_ROW_PITCH:
					cfg_q.row_pitch <= cfg_data[rfb_pkg::PITCH_W-1:0];
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	// front: raster position tagging
	rfb_front #(
		.MAX_DIM (MAX_DIM),
		.CNT_W   (CNT_W),
		.DATA_W  (DATA_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_in    (pixel_in),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// queue between front and back
	rfb_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: blend and address pipeline
	rfb_back #(
		.ADDR_BITS (ADDR_BITS),
		.CNT_W     (CNT_W),
		.DATA_W    (DATA_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_addr   (pixel_addr),
		.pixel_out    (pixel_out),
		.last_pixel   (last_pixel)
	);

endmodule
`default_nettype wire

// ===== sv/rfb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfb_front: raster position tracking
// Accepts pixel transactions, tags each with its row, column and last flag
// and pushes the tagged item into the queue.
// ----------------------------------------------------------------------------
module rfb_front #(
	parameter int unsigned MAX_DIM = 4096,
	parameter int unsigned CNT_W   = 12,
	parameter int unsigned DATA_W  = 57
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  rfb_pkg::cfg_regs_t      cfg,
	input  wire                     pixel_valid,
	output logic                    pixel_ready,
	input  wire [rfb_pkg::PIX_W-1:0] pixel_in,
	output logic                    push_valid,
	input  wire                     push_ready,
	output logic [DATA_W-1:0]       push_data
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM) + 1;
	localparam int unsigned CMP_W =
		((DIM_W > rfb_pkg::DIM_CFG_W) ? DIM_W : rfb_pkg::DIM_CFG_W) + 1;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CMP_W-1:0] last_col;
	logic [CMP_W-1:0] last_row;
	logic             row_end;
	logic             rect_end;
	logic             accept;

	// clamp a dimension to 1..MAX_DIM and return its last index
	function automatic logic [CMP_W-1:0] last_index(input logic [rfb_pkg::DIM_CFG_W-1:0] raw);
		logic [CMP_W-1:0] v;
		v = CMP_W'(raw);
		if (v == '0) begin
			v = CMP_W'(1);
		end else if (v > CMP_W'(MAX_DIM)) begin
			v = CMP_W'(MAX_DIM);
		end
		return v - CMP_W'(1);
	endfunction

	// row and rectangle end detection
	always_comb begin
		last_col = last_index(cfg.rect_width);
		last_row = last_index(cfg.rect_height);
		row_end  = CMP_W'(col_q) >= last_col;
		rect_end = row_end && (CMP_W'(row_q) >= last_row);
	end

	// handshake toward the queue
	assign pixel_ready = push_ready;
	assign push_valid  = pixel_valid;
	assign accept      = pixel_valid && push_ready;
	assign push_data   = {rect_end, row_q, col_q, pixel_in};

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (rect_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/rfb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfb_queue: short item queue
// Small register queue between the front and back sections so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module rfb_queue #(
	parameter int unsigned DATA_W = 57
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push_valid,
	output logic              push_ready,
	input  wire [DATA_W-1:0]  push_data,
	output logic              pop_valid,
	input  wire               pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int unsigned DEPTH = rfb_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/rfb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfb_back: blend and address pipeline
// Stage one blends the four channels and multiplies row by pitch; stage two
// adds offset and column and holds the result transaction.
// ----------------------------------------------------------------------------
module rfb_back #(
	parameter int unsigned ADDR_BITS = 24,
	parameter int unsigned CNT_W     = 12,
	parameter int unsigned DATA_W    = 57
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  rfb_pkg::cfg_regs_t         cfg,
	input  wire                        pop_valid,
	output logic                       pop_ready,
	input  wire [DATA_W-1:0]           pop_data,
	output logic                       result_valid,
	input  wire                        result_ready,
	output logic [rfb_pkg::OFFSET_W-1:0] pixel_addr,
	output logic [rfb_pkg::PIX_W-1:0]  pixel_out,
	output logic                       last_pixel
);

	localparam int unsigned PIX_W  = rfb_pkg::PIX_W;
	localparam int unsigned CH_W   = rfb_pkg::CH_W;
	localparam int unsigned PROD_W = CNT_W + rfb_pkg::PITCH_W;
	localparam int unsigned MAX_A  = (ADDR_BITS > rfb_pkg::OFFSET_W) ?
		ADDR_BITS : rfb_pkg::OFFSET_W;
	localparam int unsigned SUM_W  = ((MAX_A > PROD_W) ? MAX_A : PROD_W) + 1;

	logic [PIX_W-1:0]  in_pixel;
	logic [CNT_W-1:0]  in_col;
	logic [CNT_W-1:0]  in_row;
	logic              in_last;
	logic [PIX_W-1:0]  color;
	logic [PIX_W-1:0]  blended;
	logic              adv_s1;
	logic              adv_s2;
	logic [SUM_W-1:0]  addr_sum;
	logic [ADDR_BITS-1:0] addr_wrap;

	logic              valid_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [CNT_W-1:0]  col_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [rfb_pkg::OFFSET_W-1:0] addr_s2;
	logic [PIX_W-1:0]  pixel_s2;
	logic              last_s2;

	// one byte channel of the blend
	function automatic logic [CH_W-1:0] blend_ch(
		input logic [CH_W-1:0] d,
		input logic [CH_W-1:0] c,
		input rfb_pkg::blend_mode_t m
	);
		logic [CH_W:0]     sum;
		logic [2*CH_W-1:0] mul;
		logic [CH_W-1:0]   r;
		sum = {1'b0, d} + {1'b0, c};
		mul = (2*CH_W)'(d) * (2*CH_W)'(c) + (2*CH_W)'(255);
		unique case (m)
			rfb_pkg::BLEND_ADD: r = sum[CH_W] ? '1 : sum[CH_W-1:0];
			rfb_pkg::BLEND_SUB: r = (d > c) ? d - c : '0;
			rfb_pkg::BLEND_MIN: r = (d < c) ? d : c;
			rfb_pkg::BLEND_MAX: r = (d > c) ? d : c;
			rfb_pkg::BLEND_MUL: r = mul[2*CH_W-1:CH_W];
			default:            r = d;
		endcase
		return r;
	endfunction

	// unpack the queued item
	assign {in_last, in_row, in_col, in_pixel} = pop_data;

	// fill color with alpha bits adjusted by mode
	always_comb begin
		color = cfg.fill_color;
		if (!cfg.rgba_mode && (cfg.alpha_mask != '0)) begin
			case (cfg.blend_mode) inside
				rfb_pkg::BLEND_ADD, rfb_pkg::BLEND_SUB, rfb_pkg::BLEND_MAX:
					color = cfg.fill_color & ~cfg.alpha_mask;
				rfb_pkg::BLEND_MIN, rfb_pkg::BLEND_MUL:
					color = cfg.fill_color | cfg.alpha_mask;
				default:
					color = cfg.fill_color;
			endcase
		end
	end

	// four channel blend
	always_comb begin
		for (int k = 0; k < rfb_pkg::NUM_CH; k++) begin
			blended[k*CH_W +: CH_W] = blend_ch(in_pixel[k*CH_W +: CH_W],
				color[k*CH_W +: CH_W], cfg.blend_mode);
		end
	end

	// stall control
	assign adv_s2    = !valid_s2 || result_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pop_ready = adv_s1;

	// stage one: blend and row times pitch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_valid) begin
			pixel_s1 <= blended;
			prod_s1  <= PROD_W'(in_row) * PROD_W'(cfg.row_pitch);
			col_s1   <= in_col;
			last_s1  <= in_last;
		end
	end

	// address sum, wrapped to the address space
	assign addr_sum  = SUM_W'(cfg.start_offset) + SUM_W'(prod_s1) + SUM_W'(col_s1);
	assign addr_wrap = addr_sum[ADDR_BITS-1:0];

	// stage two: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			addr_s2  <= rfb_pkg::addr_out_t'(addr_wrap);
			pixel_s2 <= pixel_s1;
			last_s2  <= last_s1;
		end
	end

	assign result_valid = valid_s2;
	assign pixel_addr   = addr_s2;
	assign pixel_out    = pixel_s2;
	assign last_pixel   = last_s2;

endmodule
`default_nettype wire

// ===== dv/tb_rect_fill_blend_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rect_fill_blend_engine: self-checking bench for the rectangle fill engine
// Loads register setups while the engine is idle, streams destination pixels
// through a queue-fed driver and checks every result transaction against an
// in-bench prediction of the blended pixel, its word address and last flag.
// ----------------------------------------------------------------------------
module tb_rect_fill_blend_engine;

	localparam int ITEM_TARGET = 1950;
	localparam int HOLD_CYCLES = 300;
	localparam int DIM_LIMIT   = 4096;

	typedef struct packed {
		logic [rfb_pkg::OFFSET_W-1:0] addr;
		logic [rfb_pkg::PIX_W-1:0]    pixel;
		logic                         last;
	} surface_write_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	rfb_pkg::cfg_index_t           cfg_index    = rfb_pkg::REG_FILL_COLOR;
	logic [rfb_pkg::PIX_W-1:0]     cfg_data     = '0;
	logic                          pixel_valid  = 1'b0;
	logic                          pixel_ready;
	logic [rfb_pkg::PIX_W-1:0]     pixel_in     = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [rfb_pkg::OFFSET_W-1:0]  pixel_addr;
	logic [rfb_pkg::PIX_W-1:0]     pixel_out;
	logic                          last_pixel;

	// register shadow as seen by the engine
	logic [rfb_pkg::PIX_W-1:0]     cur_color;
	logic [rfb_pkg::MODE_W-1:0]    cur_mode;
	logic [rfb_pkg::PIX_W-1:0]     cur_alpha_mask;
	logic                          cur_rgba;
	logic [rfb_pkg::OFFSET_W-1:0]  cur_start;
	logic [rfb_pkg::DIM_CFG_W-1:0] cur_width;
	logic [rfb_pkg::DIM_CFG_W-1:0] cur_height;
	logic [rfb_pkg::PITCH_W-1:0]   cur_pitch;

	// raster position of the next pixel
	logic [rfb_pkg::DIM_CFG_W-1:0] col_cnt;
	logic [rfb_pkg::DIM_CFG_W-1:0] row_cnt;

	logic [rfb_pkg::PIX_W-1:0]     fill_pixels_q[$];
	surface_write_t                pending_writes[$];
	int                            submitted     = 0;
	int                            mismatches    = 0;
	int                            send_gap      = 0;
	int                            drain_gap     = 0;
	int                            send_idle_pct = 0;
	int                            drain_idle_pct = 0;
	logic                          hold_req      = 1'b0;
	int                            stall_left;

	rect_fill_blend_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_addr   (pixel_addr),
		.pixel_out    (pixel_out),
		.last_pixel   (last_pixel)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// zero or oversized dimensions clamp into 1 .. DIM_LIMIT
	function automatic logic [rfb_pkg::DIM_CFG_W-1:0] dim_limit(
		input logic [rfb_pkg::DIM_CFG_W-1:0] v);
		if (v == 0)
			return rfb_pkg::DIM_CFG_W'(1);
		if (v > DIM_LIMIT)
			return rfb_pkg::DIM_CFG_W'(DIM_LIMIT);
		return v;
	endfunction

	function automatic logic [rfb_pkg::OFFSET_W-1:0] pixel_word_addr(
		input logic [rfb_pkg::DIM_CFG_W-1:0] row, input logic [rfb_pkg::DIM_CFG_W-1:0] col);
		logic [63:0] a;
		a = 64'(cur_start) + 64'(row) * 64'(cur_pitch) + 64'(col);
		return a[rfb_pkg::OFFSET_W-1:0];
	endfunction

	function automatic logic [rfb_pkg::PIX_W-1:0] blended_pixel(
		input logic [rfb_pkg::PIX_W-1:0] dst);
		logic [rfb_pkg::PIX_W-1:0] c;
		logic [rfb_pkg::PIX_W-1:0] res;
		logic [rfb_pkg::CH_W-1:0]  d8;
		logic [rfb_pkg::CH_W-1:0]  c8;
		logic [rfb_pkg::CH_W:0]    sum;
		logic [15:0]               prod;
		c = cur_color;
		// color alpha bits forced by mode unless rgba mode is on
		if (!cur_rgba && cur_alpha_mask != 0) begin
			if (cur_mode == rfb_pkg::BLEND_ADD || cur_mode == rfb_pkg::BLEND_SUB ||
				cur_mode == rfb_pkg::BLEND_MAX)
				c = c & ~cur_alpha_mask;
			else if (cur_mode == rfb_pkg::BLEND_MIN || cur_mode == rfb_pkg::BLEND_MUL)
				c = c | cur_alpha_mask;
		end
		res = '0;
		for (int k = 0; k < rfb_pkg::NUM_CH; k++) begin
			d8 = dst[rfb_pkg::CH_W*k +: rfb_pkg::CH_W];
			c8 = c[rfb_pkg::CH_W*k +: rfb_pkg::CH_W];
			case (cur_mode)
				rfb_pkg::BLEND_ADD: begin
					sum = {1'b0, d8} + {1'b0, c8};
					res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] =
						sum[rfb_pkg::CH_W] ? 8'hFF : sum[rfb_pkg::CH_W-1:0];
				end
				rfb_pkg::BLEND_SUB:
					res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = (d8 > c8) ? d8 - c8 : 8'h00;
				rfb_pkg::BLEND_MIN:
					res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = (d8 < c8) ? d8 : c8;
				rfb_pkg::BLEND_MAX:
					res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = (d8 > c8) ? d8 : c8;
				rfb_pkg::BLEND_MUL: begin
					prod = 16'(d8) * 16'(c8) + 16'd255;
					res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = prod[15:8];
				end
				default: res[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = d8;
			endcase
		end
		return res;
	endfunction

	// predict the write for one accepted pixel and step the raster position
	task automatic blend_and_advance(input logic [rfb_pkg::PIX_W-1:0] dst);
		surface_write_t wr;
		logic [rfb_pkg::DIM_CFG_W-1:0] w;
		logic [rfb_pkg::DIM_CFG_W-1:0] h;
		logic row_end;
		logic rect_end;
		w = dim_limit(cur_width);
		h = dim_limit(cur_height);
		row_end  = col_cnt >= w - rfb_pkg::DIM_CFG_W'(1);
		rect_end = row_end && row_cnt >= h - rfb_pkg::DIM_CFG_W'(1);
		wr.addr  = pixel_word_addr(row_cnt, col_cnt);
		wr.pixel = blended_pixel(dst);
		wr.last  = rect_end;
		pending_writes.push_back(wr);
		if (rect_end) begin
			col_cnt = '0;
			row_cnt = '0;
		end else if (row_end) begin
			col_cnt = '0;
			row_cnt = row_cnt + rfb_pkg::DIM_CFG_W'(1);
		end else begin
			col_cnt = col_cnt + rfb_pkg::DIM_CFG_W'(1);
		end
	endtask

	// register shadow follows each config transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_color      <= '0;
			cur_mode       <= '0;
			cur_alpha_mask <= '0;
			cur_rgba       <= 1'b0;
			cur_start      <= '0;
			cur_width      <= '0;
			cur_height     <= '0;
			cur_pitch      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rfb_pkg::REG_FILL_COLOR:   cur_color      <= cfg_data;
				rfb_pkg::REG_BLEND_MODE:   cur_mode       <= cfg_data[rfb_pkg::MODE_W-1:0];
				rfb_pkg::REG_ALPHA_MASK:   cur_alpha_mask <= cfg_data;
				rfb_pkg::REG_RGBA_MODE:    cur_rgba       <= cfg_data[0];
				rfb_pkg::REG_START_OFFSET: cur_start      <= cfg_data[rfb_pkg::OFFSET_W-1:0];
				rfb_pkg::REG_RECT_WIDTH:   cur_width      <= cfg_data[rfb_pkg::DIM_CFG_W-1:0];
				rfb_pkg::REG_RECT_HEIGHT:  cur_height     <= cfg_data[rfb_pkg::DIM_CFG_W-1:0];
				rfb_pkg::REG_ROW_PITCH:    cur_pitch      <= cfg_data[rfb_pkg::PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// pixel driver: predicts on each accepted transaction, idles in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			send_gap = 0;
			col_cnt  = '0;
			row_cnt  = '0;
		end else begin
			if (pixel_valid && pixel_ready)
				blend_and_advance(pixel_in);
			if (!pixel_valid || pixel_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					pixel_valid <= 1'b0;
				end else if (fill_pixels_q.size() == 0) begin
					pixel_valid <= 1'b0;
				end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 7);
					pixel_valid <= 1'b0;
				end else begin
					pixel_valid <= 1'b1;
					pixel_in    <= fill_pixels_q.pop_front();
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_left <= 0;
		else if (hold_req)
			stall_left <= HOLD_CYCLES;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	// result monitor: checks each result transaction, stalls in bursts
	always @(posedge clk or negedge arst_n) begin : result_monitor
		surface_write_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			drain_gap = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_writes.size() == 0) begin
					$display("%0t: unexpected result addr %h pixel %h last %b",
						$time, pixel_addr, pixel_out, last_pixel);
					mismatches++;
				end else begin
					want = pending_writes.pop_front();
					if (pixel_addr !== want.addr) begin
						$display("%0t: pixel_addr expected %h actual %h",
							$time, want.addr, pixel_addr);
						mismatches++;
					end
					if (pixel_out !== want.pixel) begin
						$display("%0t: pixel_out expected %h actual %h",
							$time, want.pixel, pixel_out);
						mismatches++;
					end
					if (last_pixel !== want.last) begin
						$display("%0t: last_pixel expected %b actual %b",
							$time, want.last, last_pixel);
						mismatches++;
					end
				end
			end
			if (drain_gap != 0) begin
				drain_gap--;
				result_ready <= 1'b0;
			end else if (stall_left != 0) begin
				result_ready <= 1'b0;
			end else if (drain_idle_pct != 0 && $urandom_range(0, 99) < drain_idle_pct) begin
				drain_gap = $urandom_range(0, 7);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// one config transaction; valid stays high for a following write
	task automatic write_reg(input rfb_pkg::cfg_index_t idx,
		input logic [rfb_pkg::PIX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_setup(
		input logic [rfb_pkg::PIX_W-1:0]     color,
		input logic [rfb_pkg::MODE_W-1:0]    mode,
		input logic [rfb_pkg::PIX_W-1:0]     amask,
		input logic                          rgba,
		input logic [rfb_pkg::OFFSET_W-1:0]  start,
		input logic [rfb_pkg::DIM_CFG_W-1:0] width,
		input logic [rfb_pkg::DIM_CFG_W-1:0] height,
		input logic [rfb_pkg::PITCH_W-1:0]   pitch);
		@(posedge clk);
		write_reg(rfb_pkg::REG_FILL_COLOR, color);
		write_reg(rfb_pkg::REG_BLEND_MODE, rfb_pkg::PIX_W'(mode));
		write_reg(rfb_pkg::REG_ALPHA_MASK, amask);
		write_reg(rfb_pkg::REG_RGBA_MODE, rfb_pkg::PIX_W'(rgba));
		write_reg(rfb_pkg::REG_START_OFFSET, rfb_pkg::PIX_W'(start));
		write_reg(rfb_pkg::REG_RECT_WIDTH, rfb_pkg::PIX_W'(width));
		write_reg(rfb_pkg::REG_RECT_HEIGHT, rfb_pkg::PIX_W'(height));
		write_reg(rfb_pkg::REG_ROW_PITCH, rfb_pkg::PIX_W'(pitch));
		cfg_valid <= 1'b0;
	endtask

	// random pixel with saturated channels now and then
	function automatic logic [rfb_pkg::PIX_W-1:0] random_pixel();
		logic [rfb_pkg::PIX_W-1:0] p;
		p = $urandom;
		if ($urandom_range(0, 3) == 0)
			for (int k = 0; k < rfb_pkg::NUM_CH; k++)
				case ($urandom_range(0, 3))
					0: p[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = 8'h00;
					1: p[rfb_pkg::CH_W*k +: rfb_pkg::CH_W] = 8'hFF;
					default: ;
				endcase
		return p;
	endfunction

	task automatic queue_pixels(input int n);
		@(negedge clk);
		for (int i = 0; i < n; i++)
			fill_pixels_q.push_back(random_pixel());
		submitted += n;
	endtask

	// everything offered, accepted and returned
	task automatic wait_idle();
		@(negedge clk);
		while (fill_pixels_q.size() != 0 || pixel_valid || pending_writes.size() != 0)
			@(negedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		logic [rfb_pkg::PIX_W-1:0]     color;
		logic [rfb_pkg::MODE_W-1:0]    mode;
		logic [rfb_pkg::PIX_W-1:0]     amask;
		logic [rfb_pkg::OFFSET_W-1:0]  start;
		logic [rfb_pkg::DIM_CFG_W-1:0] width;
		logic [rfb_pkg::DIM_CFG_W-1:0] height;
		logic [rfb_pkg::PITCH_W-1:0]   pitch;
		int                            n;
		int                            phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset setup: zero geometry acts as a single pixel, add of zero color
		@(negedge clk);
		fill_pixels_q.push_back(32'h0000_0000);
		fill_pixels_q.push_back(32'hFFFF_FFFF);
		fill_pixels_q.push_back(32'h1234_5678);
		submitted += 3;
		wait_idle();

		// saturating add with alpha cleared, address wrapping past the top
		load_setup(32'h80FF_0040, rfb_pkg::BLEND_ADD, 32'hFF00_0000, 1'b0, 24'hFF_FFFE,
			13'd3, 13'd2, 14'd4);
		@(negedge clk);
		fill_pixels_q.push_back(32'h0000_0000);
		fill_pixels_q.push_back(32'hFFFF_FFFF);
		fill_pixels_q.push_back(32'h7F01_C0FF);
		fill_pixels_q.push_back(32'h8000_00BF);
		fill_pixels_q.push_back(32'h0102_0304);
		fill_pixels_q.push_back(32'hFEFD_FCFB);
		submitted += 6;
		wait_idle();

		// remaining modes, unknown codes, rgba on, no alpha, extreme geometry
		for (int m = 1; m < 8; m++) begin
			load_setup(m[0] ? 32'hFFFF_FFFF : 32'h40C0_8001, rfb_pkg::MODE_W'(m),
				(m == 3) ? 32'h0 : 32'hFF00_0000, m == 4,
				m[1] ? 24'hFF_FFFF : 24'h0, (m == 5) ? 13'd0 : 13'd8191,
				(m == 6) ? 13'd4096 : 13'd8191, (m == 2) ? 14'd0 : 14'd16383);
			@(negedge clk);
			fill_pixels_q.push_back(32'hFFFF_FFFF);
			fill_pixels_q.push_back(32'h0080_40FE);
			submitted += 2;
			wait_idle();
		end

		// random setups, geometry often changed mid-rectangle
		phase = 0;
		while (submitted < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: color = 32'h0;
				1: color = 32'hFFFF_FFFF;
				default: color = $urandom;
			endcase
			n = $urandom_range(0, 11);
			mode = (n < 10) ? rfb_pkg::MODE_W'(n % 5) :
				rfb_pkg::MODE_W'($urandom_range(5, 7));
			case ($urandom_range(0, 5))
				0: amask = 32'h0;
				1: amask = 32'h0000_00FF;
				2: amask = 32'hFFFF_FFFF;
				3: amask = $urandom;
				default: amask = 32'hFF00_0000;
			endcase
			case ($urandom_range(0, 5))
				0: start = '0;
				1: start = 24'hFF_FFFF;
				2: start = rfb_pkg::OFFSET_W'(24'hFF_FFFF - $urandom_range(0, 64));
				default: start = rfb_pkg::OFFSET_W'($urandom);
			endcase
			case ($urandom_range(0, 19))
				0: width = 13'd0;
				1: width = 13'd4096;
				2: width = rfb_pkg::DIM_CFG_W'($urandom_range(4097, 8191));
				3: width = 13'd8191;
				default: width = rfb_pkg::DIM_CFG_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 19))
				0: height = 13'd0;
				1: height = 13'd4096;
				2: height = rfb_pkg::DIM_CFG_W'($urandom_range(4097, 8191));
				3: height = 13'd8191;
				default: height = rfb_pkg::DIM_CFG_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 7))
				0: pitch = '0;
				1: pitch = 14'd16383;
				2: pitch = rfb_pkg::PITCH_W'($urandom_range(0, dim_limit(width)));
				default: pitch = rfb_pkg::PITCH_W'(dim_limit(width) + $urandom_range(0, 20));
			endcase
			if (dim_limit(width) <= 12 && dim_limit(height) <= 6)
				n = dim_limit(width) * dim_limit(height) * $urandom_range(1, 3)
					+ (($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
			else
				n = $urandom_range(5, 40);
			if (phase == 5)
				n = 80;
			if (n > ITEM_TARGET - submitted)
				n = ITEM_TARGET - submitted;

			// pacing for this phase; the tail of the run runs flat out
			if (ITEM_TARGET - submitted < 250 || phase == 5) begin
				send_idle_pct  = 0;
				drain_idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: send_idle_pct = 0;
					1: send_idle_pct = 15;
					default: send_idle_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: drain_idle_pct = 0;
					1: drain_idle_pct = 15;
					default: drain_idle_pct = 40;
				endcase
			end

			load_setup(color, mode, amask, 1'($urandom_range(0, 1)), start, width, height,
				pitch);
			if (phase == 5) begin
				// receiver holds off while the sender keeps offering
				@(negedge clk);
				hold_req = 1'b1;
				@(negedge clk);
				hold_req = 1'b0;
			end
			queue_pixels(n);
			wait_idle();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_writes.size() == 0)
			$display("tb_rect_fill_blend_engine passed");
		else
			$display("tb_rect_fill_blend_engine failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_rect_fill_blend_engine failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== rect_fill_blend_engine.f =====
sv/rfb_pkg.sv
sv/rfb_front.sv
sv/rfb_queue.sv
sv/rfb_back.sv
sv/rect_fill_blend_engine.sv
dv/tb_rect_fill_blend_engine.sv
